// ===== hdl/rjcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rjcc_pkg
// Types, constants, saturating helpers and the iteration microcode for the
// rational Julia convergence counter.
// ----------------------------------------------------------------------------
package rjcc_pkg;

    localparam int WORD_W  = 32;
    localparam int FRAC_W  = 24;
    localparam int CNT_W   = 16;
    localparam int DVD_W   = WORD_W + FRAC_W;
    localparam int IN_W    = 64;
    localparam int OUT_W   = 40;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [4:0] ridx_t;
    typedef logic [5:0] upc_t;

    localparam word_t VMAX      = 32'sh7FFF_FFFF;
    localparam word_t VMIN      = 32'sh8000_0000;
    localparam word_t FIX_ONE   = 32'sh0100_0000;
    localparam word_t FIX_F427  = word_t'(((64'd8 << FRAC_W) + 64'd27) / 64'd54);

    // configuration register indexes
    localparam logic [2:0] CFG_A_RE   = 3'd0;
    localparam logic [2:0] CFG_A_IM   = 3'd1;
    localparam logic [2:0] CFG_AT_RE  = 3'd2;
    localparam logic [2:0] CFG_AT_IM  = 3'd3;
    localparam logic [2:0] CFG_EPS    = 3'd4;
    localparam logic [2:0] CFG_PERIOD = 3'd5;
    localparam logic [2:0] CFG_LIMIT  = 3'd6;

    // working register file
    localparam ridx_t R_ZR  = 5'd0;
    localparam ridx_t R_ZI  = 5'd1;
    localparam ridx_t R_AR  = 5'd2;
    localparam ridx_t R_AI  = 5'd3;
    localparam ridx_t R_ATR = 5'd4;
    localparam ridx_t R_ATI = 5'd5;
    localparam ridx_t R_ONE = 5'd6;
    localparam ridx_t R_F4  = 5'd7;
    localparam ridx_t R_S0  = 5'd8;
    localparam ridx_t R_S1  = 5'd9;
    localparam ridx_t R_SR  = 5'd10;
    localparam ridx_t R_SI  = 5'd11;
    localparam ridx_t R_M   = 5'd12;
    localparam ridx_t R_TR  = 5'd13;
    localparam ridx_t R_TI  = 5'd14;
    localparam ridx_t R_QR  = 5'd15;
    localparam ridx_t R_QI  = 5'd16;
    localparam ridx_t R_OR  = 5'd17;
    localparam ridx_t R_OI  = 5'd18;
    localparam ridx_t R_CR  = 5'd19;
    localparam ridx_t R_CI  = 5'd20;
    localparam ridx_t R_NR  = 5'd21;
    localparam ridx_t R_NI  = 5'd22;
    localparam ridx_t R_UR  = 5'd23;
    localparam ridx_t R_UI  = 5'd24;
    localparam ridx_t R_DR  = 5'd25;
    localparam ridx_t R_DD  = 5'd26;
    localparam ridx_t R_CJ  = 5'd27;
    localparam ridx_t R_PR  = 5'd28;
    localparam ridx_t R_PI  = 5'd29;

    localparam upc_t PC_LAST = 6'd51;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_NEG,
        OP_MUL,
        OP_DIV,
        OP_CHK
    } op_t;

    typedef struct packed {
        op_t   op;
        ridx_t dst;
        ridx_t a;
        ridx_t b;
    } uop_t;

    function automatic logic [WORD_W-1:0] mag(input word_t v);
        mag = v[WORD_W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic word_t sat_add(input word_t a, input word_t b);
        logic signed [WORD_W:0] s;
        s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
        if (s[WORD_W] != s[WORD_W-1])
            sat_add = s[WORD_W] ? VMIN : VMAX;
        else
            sat_add = s[WORD_W-1:0];
    endfunction

    function automatic word_t sat_neg(input word_t a);
        sat_neg = (a == VMIN) ? VMAX : -a;
    endfunction

    function automatic word_t sat_sub(input word_t a, input word_t b);
        sat_sub = sat_add(a, sat_neg(b));
    endfunction

    function automatic word_t finish(input logic [DVD_W-1:0] q, input logic neg);
        if (q > DVD_W'(VMAX))
            finish = neg ? VMIN : VMAX;
        else if (neg)
            finish = -word_t'(q[WORD_W-1:0]);
        else
            finish = word_t'(q[WORD_W-1:0]);
    endfunction

    function automatic uop_t mk(input op_t op, input ridx_t d, input ridx_t a, input ridx_t b);
        mk = '{op: op, dst: d, a: a, b: b};
    endfunction

    // one map iteration, preceded by the distance test
    function automatic uop_t ucode(input upc_t pc);
        unique case (pc)
            6'd0:  ucode = mk(OP_SUB, R_S0, R_ZR, R_ATR);
            6'd1:  ucode = mk(OP_SUB, R_S1, R_ZI, R_ATI);
            6'd2:  ucode = mk(OP_MUL, R_S0, R_S0, R_S0);
            6'd3:  ucode = mk(OP_MUL, R_S1, R_S1, R_S1);
            6'd4:  ucode = mk(OP_ADD, R_S0, R_S0, R_S1);
            6'd5:  ucode = mk(OP_CHK, R_S0, R_S0, R_S0);
            6'd6:  ucode = mk(OP_MUL, R_S0, R_ZR, R_ZR);
            6'd7:  ucode = mk(OP_MUL, R_S1, R_ZI, R_ZI);
            6'd8:  ucode = mk(OP_SUB, R_SR, R_S0, R_S1);
            6'd9:  ucode = mk(OP_MUL, R_S0, R_ZR, R_ZI);
            6'd10: ucode = mk(OP_ADD, R_SI, R_S0, R_S0);
            6'd11: ucode = mk(OP_SUB, R_M,  R_ZR, R_ONE);
            6'd12: ucode = mk(OP_MUL, R_S0, R_SR, R_M);
            6'd13: ucode = mk(OP_MUL, R_S1, R_SI, R_ZI);
            6'd14: ucode = mk(OP_SUB, R_TR, R_S0, R_S1);
            6'd15: ucode = mk(OP_MUL, R_S0, R_SR, R_ZI);
            6'd16: ucode = mk(OP_MUL, R_S1, R_SI, R_M);
            6'd17: ucode = mk(OP_ADD, R_TI, R_S0, R_S1);
            6'd18: ucode = mk(OP_MUL, R_S0, R_AR, R_AR);
            6'd19: ucode = mk(OP_MUL, R_S1, R_AI, R_AI);
            6'd20: ucode = mk(OP_SUB, R_QR, R_S0, R_S1);
            6'd21: ucode = mk(OP_MUL, R_S0, R_AR, R_AI);
            6'd22: ucode = mk(OP_ADD, R_QI, R_S0, R_S0);
            6'd23: ucode = mk(OP_SUB, R_OR, R_ONE, R_AR);
            6'd24: ucode = mk(OP_NEG, R_OI, R_AI, R_AI);
            6'd25: ucode = mk(OP_MUL, R_S0, R_QR, R_OR);
            6'd26: ucode = mk(OP_MUL, R_S1, R_QI, R_OI);
            6'd27: ucode = mk(OP_SUB, R_CR, R_S0, R_S1);
            6'd28: ucode = mk(OP_MUL, R_S0, R_QR, R_OI);
            6'd29: ucode = mk(OP_MUL, R_S1, R_QI, R_OR);
            6'd30: ucode = mk(OP_ADD, R_CI, R_S0, R_S1);
            6'd31: ucode = mk(OP_ADD, R_NR, R_TR, R_CR);
            6'd32: ucode = mk(OP_ADD, R_NI, R_TI, R_CI);
            6'd33: ucode = mk(OP_MUL, R_S0, R_AR, R_NR);
            6'd34: ucode = mk(OP_MUL, R_S1, R_AI, R_NI);
            6'd35: ucode = mk(OP_SUB, R_UR, R_S0, R_S1);
            6'd36: ucode = mk(OP_MUL, R_S0, R_AR, R_NI);
            6'd37: ucode = mk(OP_MUL, R_S1, R_AI, R_NR);
            6'd38: ucode = mk(OP_ADD, R_UI, R_S0, R_S1);
            6'd39: ucode = mk(OP_ADD, R_DR, R_TR, R_F4);
            6'd40: ucode = mk(OP_MUL, R_S0, R_DR, R_DR);
            6'd41: ucode = mk(OP_MUL, R_S1, R_TI, R_TI);
            6'd42: ucode = mk(OP_ADD, R_DD, R_S0, R_S1);
            6'd43: ucode = mk(OP_NEG, R_CJ, R_TI, R_TI);
            6'd44: ucode = mk(OP_MUL, R_S0, R_UR, R_DR);
            6'd45: ucode = mk(OP_MUL, R_S1, R_UI, R_CJ);
            6'd46: ucode = mk(OP_SUB, R_PR, R_S0, R_S1);
            6'd47: ucode = mk(OP_MUL, R_S0, R_UR, R_CJ);
            6'd48: ucode = mk(OP_MUL, R_S1, R_UI, R_DR);
            6'd49: ucode = mk(OP_ADD, R_PI, R_S0, R_S1);
            6'd50: ucode = mk(OP_DIV, R_ZR, R_PR, R_DD);
            6'd51: ucode = mk(OP_DIV, R_ZI, R_PI, R_DD);
            default: ucode = mk(OP_CHK, R_S0, R_S0, R_S0);
        endcase
    endfunction

endpackage

// ===== hdl/rjcc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rjcc_div
// Restoring fixed-point divider, one quotient bit per cycle, saturating.
// ----------------------------------------------------------------------------
module rjcc_div
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  rjcc_pkg::word_t num,
    input  rjcc_pkg::word_t den,
    output logic           done,
    output rjcc_pkg::word_t result
);
    import rjcc_pkg::*;

    logic                run_reg, run_next;
    logic                done_reg, done_next;
    logic [5:0]          cnt_reg, cnt_next;
    logic [DVD_W-1:0]    dvd_reg, dvd_next;
    logic [DVD_W-1:0]    quot_reg, quot_next;
    logic [WORD_W-1:0]   rem_reg, rem_next;
    logic [WORD_W-1:0]   y_reg, y_next;
    logic                neg_reg, neg_next;
    word_t               res_reg, res_next;
    logic [WORD_W:0]     r2;
    logic                ge;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        y_next    = y_reg;
        neg_next  = neg_reg;
        res_next  = res_reg;
        r2        = {rem_reg, dvd_reg[DVD_W-1]};
        ge        = r2 >= {1'b0, y_reg};
        if (start)
        begin
            if (den == '0)
            begin
                res_next  = num[WORD_W-1] ? VMIN : VMAX;
                done_next = 1'b1;
            end
            else
            begin
                dvd_next  = {mag(num), {FRAC_W{1'b0}}};
                y_next    = mag(den);
                neg_next  = num[WORD_W-1] ^ den[WORD_W-1];
                rem_next  = '0;
                quot_next = '0;
                cnt_next  = 6'(DVD_W);
                run_next  = 1'b1;
            end
        end
        else if (run_reg)
        begin
            rem_next  = ge ? WORD_W'(r2 - {1'b0, y_reg}) : r2[WORD_W-1:0];
            quot_next = {quot_reg[DVD_W-2:0], ge};
            dvd_next  = {dvd_reg[DVD_W-2:0], 1'b0};
            cnt_next  = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
                res_next  = finish({quot_reg[DVD_W-2:0], ge}, neg_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        y_reg    <= y_next;
        neg_reg  <= neg_next;
        res_reg  <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ===== hdl/rational_julia_convergence_count.sv =====
`timescale 1ns / 1ps
// One iteration: 26 multiplies, two divides, 24 add, subtract, negate or check
// steps and a head state. Throughput: one item at a time, set by the shared
// multiplier and the bit-serial divider; next item accepted while the result waits.
// Reset: asynchronous, active low; control and config registers take defaults; datapath is not reset.
// ----------------------------------------------------------------------------
// rational_julia_convergence_count
// Escape-time counter for a rational map, microcoded over a shared unit.
// ----------------------------------------------------------------------------
module rational_julia_convergence_count
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [2:0]                  cfg_index,
    input  logic [31:0]                 cfg_data,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [rjcc_pkg::IN_W-1:0]   s_axis_tdata,   // start_real, start_imag
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [rjcc_pkg::OUT_W-1:0]  m_axis_tdata    // converged, steps_taken, colour_value, zero pad
);
    import rjcc_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_HEAD = 6'b000010,
        ST_EXEC = 6'b000100,
        ST_MULW = 6'b001000,
        ST_DIVW = 6'b010000,
        ST_FIN  = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    word_t              a_re_reg, a_im_reg, at_re_reg, at_im_reg;
    logic [30:0]        eps_reg;
    logic [7:0]         per_reg;
    logic [CNT_W-1:0]   lim_reg;
    word_t              rf_reg [32];
    upc_t               pc_reg, pc_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [7:0]         mod_reg, mod_next;
    logic               conv_reg, conv_next;
    logic [63:0]        prod_reg, prod_next;
    logic               mneg_reg, mneg_next;
    logic               ovalid_reg, ovalid_next;
    logic               oconv_reg, oconv_next;
    logic [CNT_W-1:0]   osteps_reg, osteps_next;
    logic [16:0]        ocol_reg, ocol_next;
    uop_t               uop;
    word_t              opa, opb;
    logic               rf_we;
    word_t              rf_wd;
    logic               step_done;
    logic               div_start, div_done;
    word_t              div_res;
    logic [7:0]         per_eff;
    logic               load;

    rjcc_div u_div
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (opa),
        .den    (opb),
        .done   (div_done),
        .result (div_res)
    );

    assign uop     = ucode(pc_reg);
    assign opa     = rf_reg[uop.a];
    assign opb     = rf_reg[uop.b];
    assign per_eff = (per_reg == 8'd0) ? 8'd1 : per_reg;
    assign load    = s_axis_tvalid && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        pc_next     = pc_reg;
        cnt_next    = cnt_reg;
        mod_next    = mod_reg;
        conv_next   = conv_reg;
        prod_next   = prod_reg;
        mneg_next   = mneg_reg;
        ovalid_next = ovalid_reg;
        oconv_next  = oconv_reg;
        osteps_next = osteps_reg;
        ocol_next   = ocol_reg;
        rf_we       = 1'b0;
        rf_wd       = '0;
        step_done   = 1'b0;
        div_start   = 1'b0;

        if (ovalid_reg && m_axis_tready)
            ovalid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cnt_next   = '0;
                    mod_next   = '0;
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD:
            begin
                pc_next = '0;
                if (cnt_reg == lim_reg)
                begin
                    conv_next  = 1'b0;
                    state_next = ST_FIN;
                end
                else
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                unique case (uop.op)
                    OP_ADD:
                    begin
                        rf_we     = 1'b1;
                        rf_wd     = sat_add(opa, opb);
                        step_done = 1'b1;
                    end
                    OP_SUB:
                    begin
                        rf_we     = 1'b1;
                        rf_wd     = sat_sub(opa, opb);
                        step_done = 1'b1;
                    end
                    OP_NEG:
                    begin
                        rf_we     = 1'b1;
                        rf_wd     = sat_neg(opa);
                        step_done = 1'b1;
                    end
                    OP_MUL:
                    begin
                        prod_next  = mag(opa) * mag(opb);
                        mneg_next  = opa[WORD_W-1] ^ opb[WORD_W-1];
                        state_next = ST_MULW;
                    end
                    OP_DIV:
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIVW;
                    end
                    OP_CHK:
                    begin
                        if (opa < $signed({1'b0, eps_reg}))
                        begin
                            conv_next  = 1'b1;
                            state_next = ST_FIN;
                        end
                        else
                            step_done = 1'b1;
                    end
                    default:
                    begin
                        step_done = 1'b1;
                    end
                endcase
            end
            ST_MULW:
            begin
                rf_we     = 1'b1;
                rf_wd     = finish(DVD_W'(prod_reg[63:FRAC_W]), mneg_reg);
                step_done = 1'b1;
            end
            ST_DIVW:
            begin
                if (div_done)
                begin
                    rf_we     = 1'b1;
                    rf_wd     = div_res;
                    step_done = 1'b1;
                end
            end
            ST_FIN:
            begin
                if (!ovalid_reg || m_axis_tready)
                begin
                    ovalid_next = 1'b1;
                    oconv_next  = conv_reg;
                    osteps_next = cnt_reg;
                    ocol_next   = conv_reg ?
                                  17'(cnt_reg) + 17'(mod_reg) * 17'd20 : 17'd0;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (step_done)
        begin
            if (pc_reg == PC_LAST)
            begin
                cnt_next   = cnt_reg + 1'b1;
                mod_next   = (mod_reg == per_eff - 8'd1) ? 8'd0 : mod_reg + 8'd1;
                state_next = ST_HEAD;
            end
            else
            begin
                pc_next    = pc_reg + 1'b1;
                state_next = ST_EXEC;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pc_reg     <= '0;
            cnt_reg    <= '0;
            mod_reg    <= '0;
            conv_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
            a_re_reg   <= FIX_ONE;
            a_im_reg   <= '0;
            at_re_reg  <= '0;
            at_im_reg  <= '0;
            eps_reg    <= 31'd1678;
            per_reg    <= 8'd10;
            lim_reg    <= 16'd100;
        end
        else
        begin
            state_reg  <= state_next;
            pc_reg     <= pc_next;
            cnt_reg    <= cnt_next;
            mod_reg    <= mod_next;
            conv_reg   <= conv_next;
            ovalid_reg <= ovalid_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_A_RE:   a_re_reg  <= cfg_data;
                    CFG_A_IM:   a_im_reg  <= cfg_data;
                    CFG_AT_RE:  at_re_reg <= cfg_data;
                    CFG_AT_IM:  at_im_reg <= cfg_data;
                    CFG_EPS:    eps_reg   <= cfg_data[30:0];
                    CFG_PERIOD: per_reg   <= cfg_data[7:0];
                    CFG_LIMIT:  lim_reg   <= cfg_data[CNT_W-1:0];
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        mneg_reg   <= mneg_next;
        oconv_reg  <= oconv_next;
        osteps_reg <= osteps_next;
        ocol_reg   <= ocol_next;
        if (load)
        begin
            rf_reg[R_ZR]  <= s_axis_tdata[31:0];
            rf_reg[R_ZI]  <= s_axis_tdata[63:32];
            rf_reg[R_AR]  <= a_re_reg;
            rf_reg[R_AI]  <= a_im_reg;
            rf_reg[R_ATR] <= at_re_reg;
            rf_reg[R_ATI] <= at_im_reg;
            rf_reg[R_ONE] <= FIX_ONE;
            rf_reg[R_F4]  <= FIX_F427;
        end
        else if (rf_we)
            rf_reg[uop.dst] <= rf_wd;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {6'd0, ocol_reg, osteps_reg, oconv_reg};

endmodule

// ===== hdl/rjcc_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rjcc_chk
// Port-level checks for the convergence counter, bound to the top level.
// ----------------------------------------------------------------------------
module rjcc_chk
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item taken while busy");

    a_nc_colour: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[33:17] == 17'd0)
        else $error("colour set on unconverged item");

    a_colour_ge: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[33:17] >= {1'b0, m_axis_tdata[16:1]})
        else $error("colour below step count");

    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[39:34] == 6'd0)
        else $error("padding not zero");

endmodule

bind rational_julia_convergence_count rjcc_chk u_rjcc_chk (.*);
